[src/cle_pkg.sv]
package cle_pkg;

	typedef enum logic [2:0] {
		ACT_INS_FRONT  = 3'd0,
		ACT_INS_END    = 3'd1,
		ACT_INS_BEFORE = 3'd2,
		ACT_INS_AFTER  = 3'd3,
		ACT_DELETE     = 3'd4,
		ACT_SEARCH     = 3'd5
	} action_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_EMPTY     = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	typedef struct packed {
		logic [2:0]         action;
		logic signed [31:0] value;
		logic signed [31:0] target_value;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [5:0] position;
	} rsp_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_FREE,
		S_WRD,
		S_WCMP,
		S_LINK_A,
		S_LINK_B,
		S_NXRD,
		S_NXUSE,
		S_DONE
	} state_t;

	// datapath commands from the controller
	typedef struct packed {
		logic load;
		logic free_clr;
		logic free_step;
		logic walk_init;
		logic walk_rd;
		logic walk_adv;
		logic nx_rd;
		logic op_a;
		logic op_b;
		logic done;
	} cmd_t;

	// status back to the controller
	typedef struct packed {
		logic       free_found;
		logic       free_end;
		logic       empty;
		logic       full;
		logic       hit;
		logic       walk_end;
		logic [2:0] action;
	} sts_t;

endpackage

[src/cle_ram.sv]
module cle_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[src/cle_ctrl.sv]
module cle_ctrl import cle_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   start,
	output logic   busy,
	input  sts_t   sts,
	output cmd_t   cmd
);

	state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = (state_q != S_IDLE);
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load     = 1'b1;
					cmd.free_clr = 1'b1;
					state_d      = S_FREE;
				end
			end
			// find the lowest free slot for inserts, start the walk for delete and search, or finish early
			S_FREE: begin
				if (sts.action > 3'd5) begin
					state_d = S_DONE;
				end else if (sts.action <= 3'd3 && sts.full) begin
					state_d = S_DONE;
				end else if (sts.action >= 3'd2 && sts.empty) begin
					state_d = S_DONE;
				end else if (sts.action <= 3'd1) begin
					if (sts.free_found) begin
						state_d = S_LINK_A;
					end else begin
						cmd.free_step = 1'b1;
					end
				end else if (sts.action >= 3'd4 || sts.free_found) begin
					cmd.walk_init = 1'b1;
					state_d       = S_WRD;
				end else begin
					cmd.free_step = 1'b1;
				end
			end
			S_WRD: begin
				cmd.walk_rd = 1'b1;
				state_d     = S_WCMP;
			end
			// compare the node read last cycle
			S_WCMP: begin
				if (sts.hit) begin
					if (sts.action == ACT_SEARCH) begin
						state_d = S_DONE;
					end else if (sts.action == ACT_INS_AFTER) begin
						cmd.nx_rd = 1'b1;
						state_d   = S_NXUSE;
					end else begin
						state_d = S_LINK_A;
					end
				end else if (sts.walk_end) begin
					state_d = S_DONE;
				end else begin
					cmd.walk_adv = 1'b1;
					state_d      = S_WRD;
				end
			end
			S_NXUSE: begin
				state_d = S_LINK_A;
			end
			S_LINK_A: begin
				cmd.op_a = 1'b1;
				state_d  = S_LINK_B;
			end
			S_LINK_B: begin
				cmd.op_b = 1'b1;
				state_d  = S_DONE;
			end
			S_DONE: begin
				cmd.done = 1'b1;
				state_d  = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

[src/cle_dp.sv]
module cle_dp import cle_pkg::*; #(
	parameter int CAPACITY    = 64,
	parameter int VALUE_WIDTH = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  req_t req,
	input  cmd_t cmd,
	output sts_t sts,
	output logic result_valid,
	output rsp_t result
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	logic [2:0]             act_q;
	logic [VALUE_WIDTH-1:0] val_q, tgt_q;
	logic [CAPACITY-1:0]    used_q;
	logic [AW-1:0]          head_q, tail_q;
	logic [CW-1:0]          count_q;
	logic [AW-1:0]          free_q;
	logic                   free_ok_q;
	logic [AW-1:0]          cur_q, prv_q;
	logic [CW-1:0]          idx_q;
	logic                   hit_q;
	logic [1:0]             st_q;
	logic [5:0]             pos_q;
	logic [AW-1:0]          nxt_q;
	logic                   valid_q;

	// node stores
	logic                   vwe, lwe;
	logic [AW-1:0]          vwa, lwa, lra;
	logic [AW-1:0]          lwd, lrd;
	logic [VALUE_WIDTH-1:0] vrd;

	cle_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(CAPACITY)) u_vals (
		.clk(clk), .we(vwe), .waddr(vwa), .wdata(val_q), .raddr(cur_q), .rdata(vrd)
	);
	cle_ram #(.WIDTH(AW), .DEPTH(CAPACITY)) u_links (
		.clk(clk), .we(lwe), .waddr(lwa), .wdata(lwd), .raddr(lra), .rdata(lrd)
	);

	logic cmp_eq;
	logic [VALUE_WIDTH-1:0] key;
	logic [CW-1:0] count_inc;
	logic first_wr;

	assign key       = (act_q <= 3'd3) ? tgt_q : val_q;
	assign cmp_eq    = (vrd == key);
	assign count_inc = count_q + CW'(1);
	assign first_wr  = (count_q == '0);
	assign lra       = cmd.nx_rd ? cur_q : cur_q;

	// status to controller
	always_comb begin
		sts.free_found = free_ok_q && !used_q[free_q];
		sts.free_end   = (free_q == AW'(CAPACITY - 1));
		sts.empty      = (count_q == '0);
		sts.full       = (count_q == CW'(CAPACITY));
		sts.hit        = cmp_eq;
		sts.walk_end   = (idx_q + CW'(1) >= count_q);
		sts.action     = act_q;
	end

	// store writes for the two link steps
	always_comb begin
		vwe = 1'b0; vwa = free_q;
		lwe = 1'b0; lwa = free_q; lwd = free_q;
		if (cmd.op_a) begin
			case (act_q)
				ACT_INS_FRONT, ACT_INS_END: begin
					vwe = 1'b1;
					lwe = 1'b1;
					lwd = first_wr ? free_q : head_q;
				end
				ACT_INS_BEFORE: begin
					vwe = 1'b1;
					lwe = 1'b1;
					lwd = cur_q;
				end
				ACT_INS_AFTER: begin
					vwe = 1'b1;
					lwe = 1'b1;
					lwd = nxt_q;
				end
				ACT_DELETE: begin
					lwe = (count_q != CW'(1));
					lwa = prv_q;
					lwd = lrd;
				end
				default: ;
			endcase
		end else if (cmd.op_b) begin
			case (act_q)
				ACT_INS_FRONT, ACT_INS_END: begin
					lwe = !first_wr;
					lwa = tail_q;
				end
				ACT_INS_BEFORE: begin
					lwe = 1'b1;
					lwa = prv_q;
				end
				ACT_INS_AFTER: begin
					lwe = 1'b1;
					lwa = cur_q;
				end
				default: ;
			endcase
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q    <= '0;
			head_q    <= '0;
			tail_q    <= '0;
			count_q   <= '0;
			valid_q   <= 1'b0;
			free_ok_q <= 1'b0;
		end else begin
			valid_q <= cmd.done;
			if (cmd.free_clr) begin
				free_ok_q <= 1'b1;
			end else if (cmd.free_step && sts.free_end) begin
				free_ok_q <= 1'b0;
			end
			if (cmd.op_a) begin
				case (act_q)
					ACT_INS_FRONT, ACT_INS_END: begin
						used_q[free_q] <= 1'b1;
						count_q        <= count_inc;
						if (first_wr) begin
							head_q <= free_q;
							tail_q <= free_q;
						end else if (act_q == ACT_INS_FRONT) begin
							head_q <= free_q;
						end
					end
					ACT_INS_BEFORE: begin
						used_q[free_q] <= 1'b1;
						count_q        <= count_inc;
						if (cur_q == head_q) begin
							head_q <= free_q;
						end
					end
					ACT_INS_AFTER: begin
						used_q[free_q] <= 1'b1;
						count_q        <= count_inc;
						if (cur_q == tail_q) begin
							tail_q <= free_q;
						end
					end
					ACT_DELETE: begin
						used_q[cur_q] <= 1'b0;
						count_q       <= count_q - CW'(1);
						if (count_q == CW'(1)) begin
							head_q <= '0;
							tail_q <= '0;
						end else begin
							if (cur_q == head_q) begin
								head_q <= lrd;
							end
							if (cur_q == tail_q) begin
								tail_q <= prv_q;
							end
						end
					end
					default: ;
				endcase
			end else if (cmd.op_b) begin
				// old tail is linked in this step, then the new node becomes tail
				if (act_q == ACT_INS_END) begin
					tail_q <= free_q;
				end
			end
		end
	end

	// payload registers, walk pointers and result
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q  <= req.action;
			val_q  <= VALUE_WIDTH'(req.value);
			tgt_q  <= VALUE_WIDTH'(req.target_value);
			free_q <= '0;
			hit_q  <= 1'b0;
			pos_q  <= '0;
			if (req.action > 3'd5) begin
				st_q <= ST_NOT_FOUND;
			end else if (req.action <= 3'd3 && count_q == CW'(CAPACITY)) begin
				st_q <= ST_FULL;
			end else if (req.action >= 3'd2 && count_q == '0) begin
				st_q <= ST_EMPTY;
			end else if (req.action <= 3'd1) begin
				st_q <= ST_OK;
			end else begin
				st_q <= ST_NOT_FOUND;
			end
		end
		if (cmd.free_step && !sts.free_end) begin
			free_q <= free_q + AW'(1);
		end
		if (cmd.walk_init) begin
			cur_q <= head_q;
			prv_q <= tail_q;
			idx_q <= '0;
		end
		if (cmd.walk_adv) begin
			prv_q <= cur_q;
			cur_q <= lrd;
			idx_q <= idx_q + CW'(1);
		end
		if (cmd.nx_rd) begin
			nxt_q <= lrd;
		end
		if (sts.action >= 3'd2 && sts.action <= 3'd5 && cmd.walk_adv == 1'b0
				&& cmd.nx_rd == 1'b0 && cmd.op_a == 1'b0 && cmd.op_b == 1'b0
				&& cmd.done == 1'b0 && cmd.walk_rd == 1'b0 && cmd.walk_init == 1'b0
				&& cmd.load == 1'b0 && cmd.free_step == 1'b0 && hit_q == 1'b0
				&& st_q == ST_NOT_FOUND && cmp_eq && idx_q < count_q) begin
			hit_q <= 1'b1;
			st_q  <= ST_OK;
			if (act_q == ACT_SEARCH) begin
				pos_q <= 6'(idx_q);
			end
		end
		if (cmd.done) begin
			result.status   <= st_q;
			result.position <= pos_q;
		end
	end

	assign result_valid = valid_q;

endmodule

[src/circular_list_engine.sv]
// channel  | signals                    | transaction
// request  | start, busy, req           | start high while busy low
// result   | result_valid, result       | one cycle strobe, no stall
//
// a plain insert scans the pool for the lowest free slot, then links the new
// node; search, delete and target inserts also walk the list node by node
// (registered node reads)
// reset clears the used map, head, tail and count at once; no clearing pass
// the result strobe is one cycle wide and cannot be held off
module circular_list_engine import cle_pkg::*; #(
	parameter int CAPACITY    = 64,
	parameter int VALUE_WIDTH = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t req,
	output logic result_valid,
	output rsp_t result
);

	cmd_t cmd;
	sts_t sts;

	cle_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .sts(sts), .cmd(cmd)
	);

	cle_dp #(.CAPACITY(CAPACITY), .VALUE_WIDTH(VALUE_WIDTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .req(req), .cmd(cmd), .sts(sts),
		.result_valid(result_valid), .result(result)
	);

endmodule

[tb/sv/circular_list_engine_tb.sv]
`timescale 1ns / 1ps

module circular_list_engine_tb;
	import cle_pkg::*;

	localparam int POOL_SIZE = 64;
	localparam int RANDOM_OPS = 1750;
	localparam int CYCLE_LIMIT = 5000000;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	req_t req;
	logic result_valid;
	rsp_t result;

	circular_list_engine u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.result_valid(result_valid),
		.result(result)
	);

	// shadow list state
	logic signed [31:0] shadow_value [POOL_SIZE];
	logic [5:0] shadow_link [POOL_SIZE];
	bit shadow_used [POOL_SIZE];
	int shadow_head;
	int shadow_tail;
	int shadow_count;

	rsp_t expected_rsp_q[$];
	int error_count;
	int cycle_count;
	bit idle_enable;

	// directed stimulus table; check_fixed marks rows with a typed-in status
	typedef struct {
		action_t act;
		logic signed [31:0] val;
		logic signed [31:0] tgt;
		bit check_fixed;
		status_t fixed_status;
	} dir_row_t;

	dir_row_t dir_table[$];

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// cycle limit
	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > CYCLE_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	// first node holding v, with its predecessor and position
	function automatic int find_slot(logic signed [31:0] v, output int prev, output int pos);
		int s;
		int p;
		s = shadow_head;
		p = shadow_tail;
		prev = 0;
		pos = 0;
		for (int i = 0; i < shadow_count; i++) begin
			if (shadow_value[s] == v) begin
				prev = p;
				pos = i;
				return s;
			end
			p = s;
			s = shadow_link[s];
		end
		return -1;
	endfunction

	function automatic int claim_slot(logic signed [31:0] v);
		for (int i = 0; i < POOL_SIZE; i++) begin
			if (!shadow_used[i]) begin
				shadow_used[i] = 1'b1;
				shadow_value[i] = v;
				shadow_link[i] = 6'(i);
				return i;
			end
		end
		return -1;
	endfunction

	function automatic void link_front(int n);
		if (shadow_count == 0) begin
			shadow_head = n;
			shadow_tail = n;
			shadow_link[n] = 6'(n);
		end else begin
			shadow_link[n] = 6'(shadow_head);
			shadow_link[shadow_tail] = 6'(n);
			shadow_head = n;
		end
		shadow_count++;
	endfunction

	function automatic void link_end(int n);
		if (shadow_count == 0) begin
			shadow_head = n;
			shadow_tail = n;
			shadow_link[n] = 6'(n);
		end else begin
			shadow_link[shadow_tail] = 6'(n);
			shadow_link[n] = 6'(shadow_head);
			shadow_tail = n;
		end
		shadow_count++;
	endfunction

	// apply one operation to the shadow list and return its response
	function automatic rsp_t apply_list_op(req_t r);
		rsp_t rsp;
		int hit;
		int prev;
		int pos;
		int n;
		rsp.status = ST_OK;
		rsp.position = '0;
		if (r.action <= ACT_INS_AFTER && shadow_count >= POOL_SIZE) begin
			rsp.status = ST_FULL;
		end else if (r.action == ACT_INS_FRONT || r.action == ACT_INS_END) begin
			n = claim_slot(r.value);
			if (r.action == ACT_INS_FRONT) link_front(n);
			else link_end(n);
		end else if (r.action <= ACT_SEARCH) begin
			if (shadow_count == 0) begin
				rsp.status = ST_EMPTY;
			end else begin
				hit = find_slot(r.action <= ACT_INS_AFTER ? r.target_value : r.value, prev, pos);
				if (hit < 0) begin
					rsp.status = ST_NOT_FOUND;
				end else if (r.action == ACT_INS_BEFORE) begin
					n = claim_slot(r.value);
					if (hit == shadow_head) begin
						link_front(n);
					end else begin
						shadow_link[n] = 6'(hit);
						shadow_link[prev] = 6'(n);
						shadow_count++;
					end
				end else if (r.action == ACT_INS_AFTER) begin
					n = claim_slot(r.value);
					shadow_link[n] = shadow_link[hit];
					shadow_link[hit] = 6'(n);
					if (hit == shadow_tail) shadow_tail = n;
					shadow_count++;
				end else if (r.action == ACT_DELETE) begin
					shadow_used[hit] = 1'b0;
					if (shadow_count == 1) begin
						shadow_head = 0;
						shadow_tail = 0;
					end else begin
						shadow_link[prev] = shadow_link[hit];
						if (hit == shadow_head) shadow_head = shadow_link[hit];
						if (hit == shadow_tail) shadow_tail = prev;
					end
					shadow_count--;
				end else begin
					rsp.position = 6'(pos);
				end
			end
		end else begin
			rsp.status = ST_NOT_FOUND;
		end
		return rsp;
	endfunction

	// send one transaction, with random idle cycles ahead of it when idle_enable is set
	task automatic issue_op(req_t r, bit check_fixed, status_t fixed_status);
		rsp_t rsp;
		while (idle_enable && $urandom_range(99, 0) < 18) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		req <= r;
		do @(posedge clk); while (busy);
		rsp = apply_list_op(r);
		if (check_fixed && rsp.status != fixed_status) begin
			$error("status: expected %0d, actual %0d", fixed_status, rsp.status);
			error_count++;
		end
		expected_rsp_q.push_back(rsp);
	endtask

	// result checker
	always @(posedge clk) begin
		rsp_t exp_rsp;
		if (arst_n && result_valid) begin
			if (expected_rsp_q.size() == 0) begin
				$error("unexpected result: status %0d position %0d", result.status,
					result.position);
				error_count++;
			end else begin
				exp_rsp = expected_rsp_q.pop_front();
				if (result.status !== exp_rsp.status) begin
					$error("status: expected %0d, actual %0d", exp_rsp.status, result.status);
					error_count++;
				end
				if (result.position !== exp_rsp.position) begin
					$error("position: expected %0d, actual %0d", exp_rsp.position,
						result.position);
					error_count++;
				end
			end
		end
	end

	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(5, 0))
			0: return 32'sh8000_0000;
			1: return 32'sh7fff_ffff;
			2: return 32'($urandom());
			default: return 32'($urandom_range(15, 0)) - 32'sd8;
		endcase
	endfunction

	function automatic void add_row(action_t a, logic signed [31:0] v, logic signed [31:0] t,
		bit fx, status_t st);
		dir_row_t row;
		row.act = a;
		row.val = v;
		row.tgt = t;
		row.check_fixed = fx;
		row.fixed_status = st;
		dir_table.push_back(row);
	endfunction

	// main stimulus
	initial begin
		req_t r;
		int wait_cycles;
		error_count = 0;
		idle_enable = 1'b1;
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		add_row(ACT_SEARCH, 32'sd1, 32'sd0, 1'b1, ST_EMPTY);
		add_row(ACT_DELETE, 32'sd1, 32'sd0, 1'b1, ST_EMPTY);
		add_row(ACT_INS_BEFORE, 32'sd1, 32'sd0, 1'b1, ST_EMPTY);
		add_row(ACT_INS_AFTER, 32'sd1, 32'sd0, 1'b1, ST_EMPTY);
		add_row(ACT_INS_FRONT, 32'sh8000_0000, 32'sd0, 1'b1, ST_OK);
		add_row(ACT_INS_END, 32'sh7fff_ffff, 32'sh7fff_ffff, 1'b1, ST_OK);
		add_row(ACT_INS_BEFORE, -32'sd1, 32'sh8000_0000, 1'b1, ST_OK);
		add_row(ACT_INS_AFTER, 32'sd5, 32'sh7fff_ffff, 1'b1, ST_OK);
		add_row(ACT_INS_BEFORE, 32'sd6, 32'sd5, 1'b0, ST_OK);
		add_row(ACT_INS_AFTER, 32'sd7, 32'sh8000_0000, 1'b0, ST_OK);
		add_row(ACT_INS_AFTER, 32'sd7, 32'sd99, 1'b1, ST_NOT_FOUND);
		add_row(ACT_SEARCH, 32'sd5, 32'sd0, 1'b0, ST_OK);
		add_row(ACT_SEARCH, 32'sd42, 32'sd0, 1'b1, ST_NOT_FOUND);
		add_row(ACT_DELETE, -32'sd1, 32'sd0, 1'b0, ST_OK);
		add_row(ACT_DELETE, 32'sd5, 32'sd0, 1'b0, ST_OK);
		add_row(ACT_DELETE, 32'sd42, 32'sd0, 1'b1, ST_NOT_FOUND);
		add_row(ACT_SEARCH, 32'sh7fff_ffff, 32'sd0, 1'b0, ST_OK);
		add_row(action_t'(3'd6), 32'sd0, 32'sd0, 1'b1, ST_NOT_FOUND);
		add_row(action_t'(3'd7), -32'sd1, -32'sd1, 1'b1, ST_NOT_FOUND);

		foreach (dir_table[i]) begin
			r.action = dir_table[i].act;
			r.value = dir_table[i].val;
			r.target_value = dir_table[i].tgt;
			issue_op(r, dir_table[i].check_fixed, dir_table[i].fixed_status);
		end

		// fill the pool to full, then try one more insert and a search to exercise full cases
		while (shadow_count < POOL_SIZE) begin
			r.action = $urandom_range(1, 0) ? ACT_INS_END : ACT_INS_FRONT;
			r.value = 32'(shadow_count);
			r.target_value = pick_value();
			issue_op(r, 1'b0, ST_OK);
		end
		r.action = ACT_INS_AFTER;
		r.value = 32'sd1;
		r.target_value = 32'sd12345;
		issue_op(r, 1'b1, ST_FULL);
		r.action = ACT_SEARCH;
		r.value = 32'sd63;
		issue_op(r, 1'b0, ST_OK);

		// sender waits for all results once
		start <= 1'b0;
		while (expected_rsp_q.size() != 0) @(posedge clk);

		for (int i = 0; i < RANDOM_OPS; i++) begin
			idle_enable = !(i >= 600 && i < 900);
			r.value = pick_value();
			r.target_value = pick_value();
			case ($urandom_range(19, 0))
				0, 1, 2, 3: r.action = ACT_INS_FRONT;
				4, 5, 6, 7: r.action = ACT_INS_END;
				8, 9: r.action = ACT_INS_BEFORE;
				10, 11: r.action = ACT_INS_AFTER;
				12, 13, 14, 15: r.action = ACT_DELETE;
				16, 17, 18: r.action = ACT_SEARCH;
				default: r.action = action_t'(3'($urandom_range(7, 6)));
			endcase
			// aim at values already in the list most of the time
			if (shadow_count > 0 && $urandom_range(3, 0) != 0) begin
				r.target_value = shadow_value[shadow_head];
				for (int k = $urandom_range(shadow_count - 1, 0); k > 0; k--)
					r.target_value = shadow_value[shadow_link[
						find_slot(r.target_value, wait_cycles, wait_cycles)]];
				if (r.action == ACT_DELETE || r.action == ACT_SEARCH)
					r.value = r.target_value;
			end
			issue_op(r, 1'b0, ST_OK);
		end

		wait_cycles = 0;
		start <= 1'b0;
		while (expected_rsp_q.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (error_count == 0 && expected_rsp_q.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
